// ----- design/ssm_pkg.sv -----
// Stripe sector mapper: shared types, constants and helpers.
// No dependencies; ssm_front, ssm_back and the top level import this package.
package ssm_pkg;

    localparam int MAX_DEVICES  = 64;
    localparam int SECTOR_BITS  = 48;
    localparam int DEV_BITS     = $clog2(MAX_DEVICES);
    localparam int CNT_BITS     = DEV_BITS + 1;
    localparam int SHIFT_BITS   = 5;
    localparam int CFG_IDX_BITS = 2;
    localparam int DIV_STAGES   = SECTOR_BITS;

    localparam logic FUNC_MAP   = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BEGIN   = 2'd0,
        CFG_SHIFT   = 2'd1,
        CFG_STRIPES = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                   func;
        logic [SECTOR_BITS-1:0] sector;
        logic [DEV_BITS-1:0]    entry_index;
        logic [SECTOR_BITS-1:0] entry_start;
    } t_in_item;

    typedef struct packed {
        logic [DEV_BITS-1:0]    device_index;
        logic [SECTOR_BITS-1:0] mapped_sector;
    } t_out_item;

    // stripes holds the effective count (1..MAX_DEVICES)
    typedef struct packed {
        logic [SECTOR_BITS-1:0] begin_sector;
        logic [SHIFT_BITS-1:0]  chunk_log2;
        logic [CNT_BITS-1:0]    stripes;
    } t_cfg;

    // classified item; low = offset within chunk (map) or start sector (write)
    typedef struct packed {
        logic                   func;
        logic [DEV_BITS-1:0]    entry_index;
        logic [SECTOR_BITS-1:0] chunk;
        logic [SECTOR_BITS-1:0] low;
    } t_job;

    // divider stage contents; dq shifts the dividend out and the quotient in
    typedef struct packed {
        logic                   func;
        logic [DEV_BITS-1:0]    entry_index;
        logic [SECTOR_BITS-1:0] low;
        logic [DEV_BITS-1:0]    rem;
        logic [SECTOR_BITS-1:0] dq;
    } t_stg;

    function automatic logic [CNT_BITS-1:0] eff_stripes(input logic [CNT_BITS-1:0] v);
        logic [CNT_BITS-1:0] r;
        if (v == '0) begin
            r = CNT_BITS'(1);
        end else if (v > CNT_BITS'(MAX_DEVICES)) begin
            r = CNT_BITS'(MAX_DEVICES);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- design/ssm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/ssm_front.sv -----
// Front end: accepts items, computes offset/chunk split, two-entry queue.
// Depends on ssm_pkg.
module ssm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssm_pkg::t_cfg     i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ssm_pkg::t_in_item i_in,
    input  logic              i_pop,
    output logic              o_head_valid,
    output ssm_pkg::t_job     o_head
);
    import ssm_pkg::*;

    logic [SECTOR_BITS-1:0] w_offset;
    logic [SECTOR_BITS-1:0] w_mask;
    t_job                   w_job;
    logic                   w_push;
    logic                   w_pop;

    t_job        r_mem [0:1];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_cnt, n_cnt;

    always_comb begin
        w_offset        = i_in.sector - i_cfg.begin_sector;
        w_mask          = ~({SECTOR_BITS{1'b1}} << i_cfg.chunk_log2);
        w_job.func        = i_in.func;
        w_job.entry_index = i_in.entry_index;
        w_job.chunk       = w_offset >> i_cfg.chunk_log2;
        w_job.low         = (i_in.func == FUNC_WRITE) ? i_in.entry_start
                                                      : (w_offset & w_mask);
    end

    assign o_in_stall   = (r_cnt == 2'd2);
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_push       = i_in_valid && !o_in_stall;
    assign w_pop        = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_job;
        end
    end
endmodule

// ----- design/ssm_back.sv -----
// Back end: pipelined chunk/stripe divider, start table, final add.
// Depends on ssm_pkg and ssm_ram.
module ssm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssm_pkg::t_cfg      i_cfg,
    input  logic               i_head_valid,
    input  ssm_pkg::t_job      i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ssm_pkg::t_out_item o_out
);
    import ssm_pkg::*;

    logic en;

    logic w_in_v [0:DIV_STAGES-1];
    t_stg w_in   [0:DIV_STAGES-1];
    logic r_v    [0:DIV_STAGES-1];
    t_stg r_st   [0:DIV_STAGES-1];

    logic                   r_rv;
    logic                   r_rfunc;
    logic [DEV_BITS-1:0]    r_rdev;
    logic [SECTOR_BITS-1:0] r_rofs;
    logic [SECTOR_BITS-1:0] w_start;
    logic                   r_out_valid;
    t_out_item              r_out;
    t_stg                   w_last;
    logic                   w_last_v;

    // whole back end advances together unless the result is held
    assign en    = !(r_out_valid && i_out_stall);
    assign o_pop = en;

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_div
            logic [CNT_BITS-1:0] w_trial;
            logic                w_ge;
            t_stg                w_nxt;

            if (k == 0) begin : g_first
                always_comb begin
                    w_in_v[k]             = i_head_valid;
                    w_in[k].func          = i_head.func;
                    w_in[k].entry_index   = i_head.entry_index;
                    w_in[k].low           = i_head.low;
                    w_in[k].rem           = '0;
                    w_in[k].dq            = i_head.chunk;
                end
            end else begin : g_rest
                always_comb begin
                    w_in_v[k] = r_v[k-1];
                    w_in[k]   = r_st[k-1];
                end
            end

            always_comb begin
                w_trial = {w_in[k].rem, w_in[k].dq[SECTOR_BITS-1]};
                w_ge    = (w_trial >= i_cfg.stripes);
                w_nxt   = w_in[k];
                w_nxt.rem = w_ge ? DEV_BITS'(w_trial - i_cfg.stripes)
                                 : DEV_BITS'(w_trial);
                w_nxt.dq  = {w_in[k].dq[SECTOR_BITS-2:0], w_ge};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (en) begin
                    r_v[k] <= w_in_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_st[k] <= w_nxt;
                end
            end
        end
    endgenerate

    assign w_last   = r_st[DIV_STAGES-1];
    assign w_last_v = r_v[DIV_STAGES-1];

    ssm_ram #(
        .WIDTH(SECTOR_BITS),
        .DEPTH(MAX_DEVICES)
    ) u_start_table (
        .i_clk  (i_clk),
        .i_we   (en && w_last_v && (w_last.func == FUNC_WRITE)),
        .i_waddr(w_last.entry_index),
        .i_wdata(w_last.low),
        .i_re   (en),
        .i_raddr(w_last.rem),
        .o_rdata(w_start)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_rv        <= w_last_v;
            r_out_valid <= r_rv && (r_rfunc == FUNC_MAP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rfunc             <= w_last.func;
            r_rdev              <= w_last.rem;
            r_rofs              <= (w_last.dq << i_cfg.chunk_log2) | w_last.low;
            r_out.device_index  <= r_rdev;
            r_out.mapped_sector <= w_start + r_rofs;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_rem_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_v |-> ({1'b0, w_last.rem} < i_cfg.stripes))
        else $error("divider remainder not below stripe count");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("result valid after reset");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_rv && (r_rfunc == FUNC_WRITE)) |=> !o_out_valid)
        else $error("table write produced a result");
`endif
endmodule

// ----- design/stripe_sector_mapper.sv -----
// Top level of the stripe sector mapper: configuration registers, front, back.
// Depends on ssm_pkg, ssm_front, ssm_back (and ssm_ram through ssm_back).
//
// Maps a logical sector to (device, physical sector) for a striped set, and
// takes start-table writes as a second item kind (func=1, no result). Items
// are accepted one per clock while o_in_stall is low; a two-entry queue sits
// between the front, which forms offset = sector - begin_sector and splits it
// at the chunk size, and the back, a 48-stage restoring divider (one quotient
// bit per stage) that divides the chunk number by the stripe count, then a
// start-table read stage and a final add into the output register. When
// nothing stalls, throughput is one item per cycle. When the output is held,
// the whole back end holds and the queue fills, after which o_in_stall rises.
// Table writes travel the same pipeline so they stay ordered with maps.
// Stripe count is taken from the low 7 bits of the config data; 0 acts as 1,
// values above 64 saturate to 64. Config writes are only allowed while the
// block is idle. Mapping through a table entry never written since reset
// gives an undefined sector.
module stripe_sector_mapper (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  ssm_pkg::t_in_item                i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ssm_pkg::t_out_item               o_out,
    input  logic                             i_cfg_we,
    input  logic [ssm_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [ssm_pkg::SECTOR_BITS-1:0]  i_cfg_data
);
    import ssm_pkg::*;

    t_cfg r_cfg;
    logic w_pop;
    logic w_head_valid;
    t_job w_head;

    // config registers; stripe count stored already clamped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.begin_sector <= '0;
            r_cfg.chunk_log2   <= SHIFT_BITS'(3);
            r_cfg.stripes      <= CNT_BITS'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BEGIN:   r_cfg.begin_sector <= i_cfg_data;
                CFG_SHIFT:   r_cfg.chunk_log2   <= i_cfg_data[SHIFT_BITS-1:0];
                CFG_STRIPES: r_cfg.stripes      <= eff_stripes(i_cfg_data[CNT_BITS-1:0]);
                default: begin
                end
            endcase
        end
    end

    ssm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_pop       (w_pop),
        .o_head_valid(w_head_valid),
        .o_head      (w_head)
    );

    ssm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head_valid(w_head_valid),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );
endmodule
